@@ hdl/wrwd_pkg.sv @@
// ----------------------------------------------------------------------------
// wrwd_pkg: shared types and constants of the windowed rms decimator
// payload structs, register indexes and fixed arithmetic widths
// ----------------------------------------------------------------------------
package wrwd_pkg;

    // sample width of the input field
    localparam int SAMPLE_BITS = 16;

    // configuration port widths
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_FRAMES_PER_PIXEL = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_COUNT      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SKIP_FRAMES      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ZOOM_GAIN        = 3'd4;

    // smallest zoom gain, about 0.1 in q8.8
    localparam logic [15:0] MIN_ZOOM = 16'd26;

    // input item
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          end_of_buffer;
    } t_in;

    // result item
    typedef struct packed {
        logic [15:0] level;
        logic [11:0] pixel_index;
        logic        last;
    } t_out;

endpackage

@@ hdl/windowed_rms_waveform_decimator.sv @@
// ----------------------------------------------------------------------------
// windowed_rms_waveform_decimator: rms level meter for a waveform display
// sums squares of interleaved samples over windows of frames and produces
// one zoomed rms level per window, tagged with its pixel index
// ----------------------------------------------------------------------------
// Usage
//   input channel: one interleaved sample per transfer, with end_of_buffer set
//   on the final sample of the buffer. output channel: level, pixel_index and
//   last. config channel: register index and data, accepted only while the
//   sequencer is idle; a pending write holds off the sample channel, and a
//   write to register index 0 to 4 restarts the pass.
//   A sample that completes no window is accepted, squared through the shared
//   multiplier and accumulated. A sample that closes a window goes on through
//   31 restoring divide steps, a root load and 16 square root steps on one
//   shared subtractor, one gain multiply and the output register load.
//   Reset loads the register defaults and clears the pass state; no sweep.
//   The result waits in an output register; while the receiver stalls a
//   finished level holds the block until it moves into that register, and
//   the next sample is taken once it does.
// ----------------------------------------------------------------------------
module windowed_rms_waveform_decimator #(
    parameter int MAX_PIXELS   = 4096,
    parameter int MAX_CHANNELS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // sample channel
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  wrwd_pkg::t_in                     i_in_data,
    // level channel
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output wrwd_pkg::t_out                    o_out_data,
    // configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [wrwd_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [wrwd_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import wrwd_pkg::*;

    // derived widths
    localparam int CP_W    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CHC_W   = 6;
    localparam int PIX_W   = $clog2(MAX_PIXELS + 1);
    localparam int CMP_W   = ((PIX_W > 13) ? PIX_W : 13) + 1;
    localparam int TALLY_W = 17 + $clog2(MAX_CHANNELS);
    localparam int MEAN_W  = 2 * SAMPLE_BITS - 1;
    localparam int SUM_W   = TALLY_W + MEAN_W;
    localparam int SQ_ITER = (MEAN_W + 1) / 2;
    localparam int SQ_W    = 2 * SQ_ITER;
    localparam int SUB_W   = (TALLY_W + 1 > SQ_W) ? TALLY_W + 1 : SQ_W;
    localparam int CNT_W   = $clog2(MEAN_W);
    localparam int PROD_W  = 2 * SAMPLE_BITS;

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQR  = 3'd1;
    localparam logic [2:0] ST_ADD  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_SQRT = 3'd4;
    localparam logic [2:0] ST_MUL  = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    // configuration registers
    logic [15:0]          r_fpp;
    logic [3:0]           r_ch;
    logic [12:0]          r_pc;
    logic [23:0]          r_skip_frames;
    logic [15:0]          r_zoom;

    // pass state
    logic [23:0]          r_skip_left;
    logic [CP_W-1:0]      r_cp;
    logic [15:0]          r_wfc;
    logic [SUM_W-1:0]     r_sum;
    logic [TALLY_W-1:0]   r_tally;
    logic [PIX_W-1:0]     r_pix;
    logic                 r_finished;

    // sequencer and per-item flags
    logic [2:0]           r_state;
    logic [CNT_W-1:0]     r_cnt;
    logic [SAMPLE_BITS-1:0] r_mag;
    logic [PROD_W-1:0]    r_sq;
    logic                 r_add;
    logic                 r_emit;
    logic                 r_clear;
    logic                 r_e_last;
    logic [11:0]          r_e_pix;
    logic [TALLY_W-1:0]   r_e_tally;

    // divider and root registers
    logic [TALLY_W-1:0]   r_rem;
    logic [MEAN_W-1:0]    r_quo;
    logic [SQ_W-1:0]      r_rt_v;
    logic [SQ_W-1:0]      r_rt_res;
    logic [SQ_W-1:0]      r_rt_bit;
    logic [15:0]          r_lvl;

    // output register
    logic                 r_out_valid;
    t_out                 r_out;

    // effective configuration values
    logic [CHC_W-1:0]     eff_ch;
    logic [CMP_W-1:0]     eff_pix;
    logic [15:0]          eff_fpp;
    logic [15:0]          eff_gain;

    always_comb begin
        if (r_ch == 4'd0) begin
            eff_ch = CHC_W'(1);
        end else if (CHC_W'(r_ch) > CHC_W'(MAX_CHANNELS)) begin
            eff_ch = CHC_W'(MAX_CHANNELS);
        end else begin
            eff_ch = CHC_W'(r_ch);
        end
        if (r_pc == 13'd0) begin
            eff_pix = CMP_W'(1);
        end else if (CMP_W'(r_pc) > CMP_W'(MAX_PIXELS)) begin
            eff_pix = CMP_W'(MAX_PIXELS);
        end else begin
            eff_pix = CMP_W'(r_pc);
        end
        eff_fpp  = (r_fpp == 16'd0) ? 16'd1 : r_fpp;
        eff_gain = (r_zoom < MIN_ZOOM) ? MIN_ZOOM : r_zoom;
    end

    // sample bookkeeping at the accept edge
    logic                 in_xfer;
    logic                 frame_end;
    logic                 n_add;
    logic [TALLY_W-1:0]   n_tally;
    logic [15:0]          n_wfc;
    logic                 win_done;
    logic                 n_emit;
    logic                 n_last;
    logic [CMP_W-1:0]     pix_next;
    logic [SAMPLE_BITS-1:0] n_mag;

    assign in_xfer  = i_in_valid && o_in_ready;
    assign pix_next = CMP_W'(r_pix) + CMP_W'(1);
    assign n_mag    = i_in_data.sample[SAMPLE_BITS-1] ?
                      (~i_in_data.sample + 1'b1) : i_in_data.sample;

    always_comb begin
        frame_end = (CHC_W'(r_cp) + CHC_W'(1)) >= eff_ch;
        n_add     = (r_skip_left == 24'd0);
        n_tally   = n_add ? r_tally + TALLY_W'(1) : r_tally;
        n_wfc     = (n_add && frame_end) ? r_wfc + 16'd1 : r_wfc;
        win_done  = n_add && frame_end && (n_wfc >= eff_fpp) && !i_in_data.end_of_buffer;
        n_emit    = win_done || (i_in_data.end_of_buffer && (n_tally != '0));
        n_last    = i_in_data.end_of_buffer || (pix_next >= eff_pix);
    end

    // shared multiplier: squares in ST_SQR, applies gain in ST_MUL
    logic [SAMPLE_BITS-1:0] mul_a;
    logic [SAMPLE_BITS-1:0] mul_b;
    logic [PROD_W-1:0]      mul_p;

    assign mul_a = (r_state == ST_SQR) ? r_mag : r_rt_res[SQ_ITER-1:0];
    assign mul_b = (r_state == ST_SQR) ? r_mag : eff_gain;
    assign mul_p = mul_a * mul_b;

    // shared subtractor: divide steps and root steps
    logic [SUB_W-1:0]     sub_a;
    logic [SUB_W-1:0]     sub_b;
    logic [SUB_W:0]       sub_d;
    logic                 sub_ge;

    always_comb begin
        if (r_state == ST_DIV) begin
            sub_a = SUB_W'({r_rem, r_quo[MEAN_W-1]});
            sub_b = SUB_W'(r_e_tally);
        end else begin
            sub_a = SUB_W'(r_rt_v);
            sub_b = SUB_W'(r_rt_res | r_rt_bit);
        end
        sub_d  = {1'b0, sub_a} - {1'b0, sub_b};
        sub_ge = !sub_d[SUB_W];
    end

    // window sum including the squared sample
    logic [SUM_W-1:0]     sum_new;
    assign sum_new = r_add ? r_sum + SUM_W'(r_sq) : r_sum;

    // rounding and saturation of the gained root
    logic [PROD_W:0]      lvl_round;
    logic [PROD_W-8:0]    lvl_shift;
    assign lvl_round = {1'b0, mul_p} + (PROD_W+1)'(128);
    assign lvl_shift = lvl_round[PROD_W:8];

    // output register takes a finished level when it is empty or draining
    logic                 out_load;
    assign out_load = (r_state == ST_OUT) && (!r_out_valid || i_out_ready);

    // handshakes, configuration only between items and ahead of samples
    assign o_in_ready  = (r_state == ST_IDLE) && !i_cfg_valid;
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // sequencer, pass state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fpp         <= 16'd1;
            r_ch          <= 4'd1;
            r_pc          <= 13'd1;
            r_skip_frames <= 24'd0;
            r_zoom        <= 16'd256;
            r_skip_left   <= 24'd0;
            r_cp          <= '0;
            r_wfc         <= 16'd0;
            r_sum         <= '0;
            r_tally       <= '0;
            r_pix         <= '0;
            r_finished    <= 1'b0;
            r_state       <= ST_IDLE;
            r_rt_bit      <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            // output register loads a level or drains on transfer
            if (out_load) begin
                r_out_valid       <= 1'b1;
                r_out.level       <= r_lvl;
                r_out.pixel_index <= r_e_pix;
                r_out.last        <= r_e_last;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (in_xfer) begin
                        r_mag   <= n_mag;
                        r_state <= ST_SQR;
                        if (r_finished) begin
                            // finished pass: wait for the buffer end
                            r_add   <= 1'b0;
                            r_emit  <= 1'b0;
                            r_clear <= i_in_data.end_of_buffer;
                            if (i_in_data.end_of_buffer) begin
                                r_skip_left <= r_skip_frames;
                                r_cp        <= '0;
                                r_wfc       <= 16'd0;
                                r_tally     <= '0;
                                r_pix       <= '0;
                                r_finished  <= 1'b0;
                            end
                        end else begin
                            r_add     <= n_add;
                            r_emit    <= n_emit;
                            r_e_last  <= n_last;
                            r_e_pix   <= pix_next[11:0] - 12'd1;
                            r_e_tally <= n_tally;
                            if (i_in_data.end_of_buffer) begin
                                // buffer end restarts the pass
                                r_clear     <= 1'b1;
                                r_skip_left <= r_skip_frames;
                                r_cp        <= '0;
                                r_wfc       <= 16'd0;
                                r_tally     <= '0;
                                r_pix       <= '0;
                                r_finished  <= 1'b0;
                            end else begin
                                if (!n_add && frame_end) begin
                                    r_skip_left <= r_skip_left - 24'd1;
                                end
                                r_cp <= frame_end ? '0 : r_cp + CP_W'(1);
                                if (n_emit) begin
                                    r_clear    <= 1'b1;
                                    r_pix      <= pix_next[PIX_W-1:0];
                                    r_finished <= (pix_next >= eff_pix);
                                    r_wfc      <= 16'd0;
                                    r_tally    <= '0;
                                end else begin
                                    r_clear <= 1'b0;
                                    r_wfc   <= n_wfc;
                                    r_tally <= n_tally;
                                end
                            end
                        end
                    end
                end
                ST_SQR: begin
                    r_sq    <= mul_p;
                    r_state <= ST_ADD;
                end
                ST_ADD: begin
                    r_sum <= r_clear ? '0 : sum_new;
                    if (r_emit) begin
                        r_rem   <= sum_new[SUM_W-1:MEAN_W];
                        r_quo   <= sum_new[MEAN_W-1:0];
                        r_cnt   <= CNT_W'(MEAN_W - 1);
                        r_state <= ST_DIV;
                    end else begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_DIV: begin
                    // one restoring divide step per cycle
                    r_quo <= {r_quo[MEAN_W-2:0], sub_ge};
                    r_rem <= sub_ge ? sub_d[TALLY_W-1:0]
                                    : {r_rem[TALLY_W-2:0], r_quo[MEAN_W-1]};
                    if (r_cnt == '0) begin
                        r_state <= ST_SQRT;
                        r_cnt   <= CNT_W'(SQ_ITER - 1);
                    end else begin
                        r_cnt <= r_cnt - CNT_W'(1);
                    end
                end
                ST_SQRT: begin
                    // one root digit per cycle, first cycle loads the quotient
                    if (r_cnt == CNT_W'(SQ_ITER - 1) && r_rt_bit == '0) begin
                        r_rt_v   <= SQ_W'(r_quo);
                        r_rt_res <= '0;
                        r_rt_bit <= SQ_W'(1) << (SQ_W - 2);
                    end else begin
                        if (sub_ge) begin
                            r_rt_v   <= sub_d[SQ_W-1:0];
                            r_rt_res <= (r_rt_res >> 1) | r_rt_bit;
                        end else begin
                            r_rt_res <= r_rt_res >> 1;
                        end
                        r_rt_bit <= r_rt_bit >> 2;
                        if (r_cnt == '0) begin
                            r_state <= ST_MUL;
                        end else begin
                            r_cnt <= r_cnt - CNT_W'(1);
                        end
                    end
                end
                ST_MUL: begin
                    r_lvl    <= (|lvl_shift[PROD_W-8:16]) ? 16'hFFFF : lvl_shift[15:0];
                    r_rt_bit <= '0;
                    r_state  <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase

            // register write restarts the pass
            if (i_cfg_valid && o_cfg_ready && i_cfg_index <= REG_ZOOM_GAIN) begin
                case (i_cfg_index)
                    REG_FRAMES_PER_PIXEL: r_fpp         <= i_cfg_data[15:0];
                    REG_CHANNEL_COUNT:    r_ch          <= i_cfg_data[3:0];
                    REG_PIXEL_COUNT:      r_pc          <= i_cfg_data[12:0];
                    REG_SKIP_FRAMES:      r_skip_frames <= i_cfg_data[23:0];
                    REG_ZOOM_GAIN:        r_zoom        <= i_cfg_data[15:0];
                    default:              r_zoom        <= r_zoom;
                endcase
                r_skip_left <= (i_cfg_index == REG_SKIP_FRAMES) ? i_cfg_data[23:0]
                                                                : r_skip_frames;
                r_cp       <= '0;
                r_wfc      <= 16'd0;
                r_sum      <= '0;
                r_tally    <= '0;
                r_pix      <= '0;
                r_finished <= 1'b0;
            end
        end
    end

    // divider remainder stays below the divisor
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_rem < r_e_tally))
        else $error("divider remainder not below divisor");

    // a level is produced only from a nonempty window
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ADD && r_emit) |-> (r_e_tally != '0))
        else $error("level requested from an empty window");

    // root fits the multiplier operand before the gain step
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL) |-> (r_rt_res[SQ_W-1:SQ_ITER] == '0))
        else $error("root wider than the multiplier operand");

    // an emitting accumulate always enters the divider next
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ADD && r_emit) |=> (r_state == ST_DIV))
        else $error("window close did not start the divider");

    // a finished pass has produced at least one level
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_finished |-> (r_pix != '0))
        else $error("pass finished with no level produced");

endmodule

@@ tb/tb_windowed_rms_waveform_decimator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_windowed_rms_waveform_decimator: self-checking bench of the rms decimator
// walks a directed table, then random buffers under several register settings
// with random idling on both channels. every level transfer is compared field
// by field against its typed table row or a cycle-free software predictor of the pass and window state
// ----------------------------------------------------------------------------
module tb_windowed_rms_waveform_decimator;
    import wrwd_pkg::*;

    localparam int CYCLE_LIMIT   = 300_000;
    localparam int SETTLE_CYCLES = 64;
    localparam int LONG_HOLD     = 400;
    localparam int PHASES        = 12;
    localparam int PHASE_ITEMS   = 28;
    localparam int FULL_PIXELS   = 4096;
    localparam int WIDE_ITEMS    = 40;

    typedef enum logic {ROW_WRITE, ROW_SAMPLE} t_row_kind;

    typedef struct {
        t_row_kind               kind;
        logic [CFG_INDEX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0]   reg_value;
        t_in                     item;
        bit                      typed;
        t_out                    want;
    } t_step_row;

    // dut connections
    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    i_in_valid  = 1'b0;
    logic                    o_in_ready;
    t_in                     i_in_data   = '0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    t_out                    o_out_data;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_INDEX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data  = '0;

    // bench control and bookkeeping
    bit          sender_idles    = 1'b1;
    bit          receiver_idles  = 1'b1;
    bit          hold_off_request = 1'b0;
    int unsigned cycle_count     = 0;
    int unsigned fail_count      = 0;
    int unsigned samples_sent    = 0;
    int unsigned levels_checked  = 0;
    int unsigned writes_done     = 0;
    t_out        levels_due[$];
    t_step_row   directed_steps[$];

    // predictor copy of the registers
    logic [15:0] cfg_fpp;
    logic [3:0]  cfg_channels;
    logic [12:0] cfg_pixels;
    logic [23:0] cfg_skip;
    logic [15:0] cfg_zoom;

    // predictor copy of the pass state
    logic [23:0] skip_left;
    logic [2:0]  chan_pos;
    logic [15:0] win_frames;
    logic [49:0] sq_sum;
    logic [19:0] tally;
    logic [12:0] pixel_no;
    bit          pass_done;

    windowed_rms_waveform_decimator DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    always #4 i_clk = ~i_clk;

    // append helpers for the expectation queue and the directed table
    function automatic void queue_level(t_out lvl);
        levels_due.insert(levels_due.size(), lvl);
    endfunction

    function automatic void add_row(t_step_row r);
        directed_steps.insert(directed_steps.size(), r);
    endfunction

    // effective register values after clamping
    function automatic int unsigned eff_channels();
        if (cfg_channels == 0) return 1;
        if (cfg_channels > 8) return 8;
        return cfg_channels;
    endfunction

    function automatic int unsigned eff_pixels();
        if (cfg_pixels == 0) return 1;
        if (cfg_pixels > FULL_PIXELS) return FULL_PIXELS;
        return cfg_pixels;
    endfunction

    function automatic int unsigned eff_fpp();
        return (cfg_fpp == 0) ? 1 : cfg_fpp;
    endfunction

    // bitwise floor of the square root
    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned trial;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            trial = r | (64'd1 << b);
            if (trial * trial <= v) r = trial;
        end
        return r;
    endfunction

    task automatic restart_pass();
        skip_left  = cfg_skip;
        chan_pos   = '0;
        win_frames = '0;
        sq_sum     = '0;
        tally      = '0;
        pixel_no   = '0;
        pass_done  = 1'b0;
    endtask

    // close the running window into one zoomed level
    task automatic close_window(input bit at_end, output t_out lvl);
        longint unsigned sum_wide;
        longint unsigned mean;
        longint unsigned scaled;
        logic [15:0]     gain;
        sum_wide = sq_sum;
        mean     = (tally != 0) ? sum_wide / tally : 0;
        gain     = (cfg_zoom < MIN_ZOOM) ? MIN_ZOOM : cfg_zoom;
        scaled   = (floor_sqrt(mean) * gain + 128) >> 8;
        lvl.level       = (scaled > 65535) ? 16'hFFFF : scaled[15:0];
        lvl.pixel_index = pixel_no[11:0];
        lvl.last        = at_end || (pixel_no + 1 >= eff_pixels());
        pixel_no = pixel_no + 1;
        if (pixel_no >= eff_pixels()) pass_done = 1'b1;
        win_frames = '0;
        sq_sum     = '0;
        tally      = '0;
    endtask

    // expected outcome of one accepted sample
    task automatic predict_level(input t_in item, output bit produced, output t_out lvl);
        bit              frame_end;
        longint signed   v;
        produced = 1'b0;
        lvl      = '0;
        if (pass_done) begin
            if (item.end_of_buffer) restart_pass();
            return;
        end
        frame_end = (int'(chan_pos) + 1 >= eff_channels());
        if (skip_left != 0) begin
            if (frame_end) skip_left = skip_left - 1;
        end else begin
            v      = item.sample;
            sq_sum = sq_sum + 50'(v * v);
            tally  = tally + 1;
            if (frame_end) begin
                win_frames = win_frames + 1;
                if (win_frames >= eff_fpp() && !item.end_of_buffer) begin
                    close_window(1'b0, lvl);
                    produced = 1'b1;
                end
            end
        end
        chan_pos = frame_end ? 3'd0 : chan_pos + 3'd1;
        if (item.end_of_buffer) begin
            if (tally != 0) begin
                close_window(1'b1, lvl);
                produced = 1'b1;
            end
            restart_pass();
        end
    endtask

    // register write, only once the block has drained
    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        i_in_valid <= 1'b0;
        while (levels_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_FRAMES_PER_PIXEL: cfg_fpp      = value[15:0];
            REG_CHANNEL_COUNT:    cfg_channels = value[3:0];
            REG_PIXEL_COUNT:      cfg_pixels   = value[12:0];
            REG_SKIP_FRAMES:      cfg_skip     = value[23:0];
            REG_ZOOM_GAIN:        cfg_zoom     = value[15:0];
            default: ;
        endcase
        restart_pass();
        writes_done++;
    endtask

    // one sample transfer, expectation queued on acceptance
    task automatic send_sample(input t_in item, input bit typed, input t_out want);
        int unsigned gap;
        bit          produced;
        t_out        lvl;
        gap = sender_idles ? $urandom_range(0, 7) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        predict_level(item, produced, lvl);
        if (typed) queue_level(want);
        else if (produced) queue_level(lvl);
        samples_sent++;
    endtask

    // random sample, biased toward full scale and zero
    function automatic logic signed [15:0] random_sample();
        case ($urandom_range(0, 7))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            3: return 16'shFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // directed table rows
    function automatic t_step_row reg_row(logic [CFG_INDEX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] value);
        t_step_row r;
        r.kind      = ROW_WRITE;
        r.reg_index = idx;
        r.reg_value = value;
        r.item      = '0;
        r.typed     = 1'b0;
        r.want      = '0;
        return r;
    endfunction

    function automatic t_step_row smp_row(logic signed [15:0] s, logic eob);
        t_step_row r;
        r.kind               = ROW_SAMPLE;
        r.reg_index          = '0;
        r.reg_value          = '0;
        r.item.sample        = s;
        r.item.end_of_buffer = eob;
        r.typed              = 1'b0;
        r.want               = '0;
        return r;
    endfunction

    function automatic t_step_row typed_row(logic signed [15:0] s, logic eob,
                                            logic [15:0] level, logic [11:0] index,
                                            logic last);
        t_step_row r;
        r = smp_row(s, eob);
        r.typed            = 1'b1;
        r.want.level       = level;
        r.want.pixel_index = index;
        r.want.last        = last;
        return r;
    endfunction

    // cycle limit
    initial begin : watchdog
        while (cycle_count <= CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    // level receiver with random stalls and one long hold-off
    initial begin : level_sink
        int unsigned wait_cycles;
        t_out        want;
        forever begin
            if (hold_off_request) begin
                wait_cycles      = LONG_HOLD;
                hold_off_request = 1'b0;
            end else begin
                wait_cycles = receiver_idles ? $urandom_range(0, 7) : 0;
            end
            if (wait_cycles != 0) begin
                i_out_ready <= 1'b0;
                repeat (wait_cycles) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            if (levels_due.size() == 0) begin
                $error("level transfer with nothing expected: level %0d pixel_index %0d last %0b",
                       o_out_data.level, o_out_data.pixel_index, o_out_data.last);
                fail_count++;
            end else begin
                want = levels_due.pop_front();
                if (o_out_data.level !== want.level) begin
                    $error("level: expected %0d, got %0d", want.level, o_out_data.level);
                    fail_count++;
                end
                if (o_out_data.pixel_index !== want.pixel_index) begin
                    $error("pixel_index: expected %0d, got %0d",
                           want.pixel_index, o_out_data.pixel_index);
                    fail_count++;
                end
                if (o_out_data.last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, o_out_data.last);
                    fail_count++;
                end
                levels_checked++;
            end
        end
    end

    // main stimulus
    initial begin : stimulus
        t_step_row   row;
        t_in         item;
        logic [15:0] fpp;
        logic [3:0]  chans;
        logic [12:0] pix;
        logic [23:0] skip;
        logic [15:0] zoom;
        int unsigned span;
        int unsigned len;
        int unsigned sent;

        // register defaults
        cfg_fpp      = 16'd1;
        cfg_channels = 4'd1;
        cfg_pixels   = 13'd1;
        cfg_skip     = 24'd0;
        cfg_zoom     = 16'd256;
        restart_pass();

        // defaults: one frame, one channel, one pixel per pass
        add_row(typed_row(16'sh0000, 1'b0, 16'd0, 12'd0, 1'b1));
        add_row(smp_row(16'sh1234, 1'b0));   // pass finished, ignored
        add_row(smp_row(16'sh0005, 1'b1));   // marker restarts the pass
        add_row(typed_row(16'sh8000, 1'b0, 16'd32768, 12'd0, 1'b1));
        add_row(smp_row(16'sh0000, 1'b1));
        add_row(typed_row(16'sh7FFF, 1'b1, 16'd32767, 12'd0, 1'b1));
        add_row(smp_row(16'sh0001, 1'b1));
        // stereo, two frames per window, partial frame at buffer end
        add_row(reg_row(REG_PIXEL_COUNT, 24'd3));
        add_row(reg_row(REG_CHANNEL_COUNT, 24'd2));
        add_row(reg_row(REG_FRAMES_PER_PIXEL, 24'd2));
        add_row(smp_row(16'sh0003, 1'b0));
        add_row(smp_row(-16'sd4, 1'b0));
        add_row(smp_row(16'sh0000, 1'b0));
        add_row(smp_row(16'sh0000, 1'b0));
        add_row(smp_row(16'sh0007, 1'b1));
        // buffer ends while still skipping: no level
        add_row(reg_row(REG_SKIP_FRAMES, 24'd1));
        add_row(smp_row(16'sh0009, 1'b1));
        // zoom below the floor is clamped
        add_row(reg_row(REG_ZOOM_GAIN, 24'd0));
        add_row(smp_row(16'sd1000, 1'b0));
        add_row(smp_row(-16'sd1000, 1'b0));
        add_row(smp_row(16'sd20000, 1'b0));
        add_row(smp_row(-16'sd20000, 1'b0));
        add_row(smp_row(16'sh7FFF, 1'b0));
        add_row(smp_row(16'sh8000, 1'b0));
        add_row(smp_row(16'sh0005, 1'b1));
        // zero and oversized counts, maximum zoom saturates
        add_row(reg_row(REG_FRAMES_PER_PIXEL, 24'd0));
        add_row(reg_row(REG_CHANNEL_COUNT, 24'd0));
        add_row(reg_row(REG_PIXEL_COUNT, 24'd8191));
        add_row(reg_row(REG_SKIP_FRAMES, 24'd0));
        add_row(reg_row(REG_ZOOM_GAIN, 24'd65535));
        add_row(typed_row(16'sh8000, 1'b0, 16'hFFFF, 12'd0, 1'b0));
        add_row(smp_row(16'sh7FFF, 1'b0));
        add_row(smp_row(16'sh0000, 1'b1));

        // reset
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (directed_steps[i]) begin
            row = directed_steps[i];
            if (row.kind == ROW_WRITE) write_register(row.reg_index, row.reg_value);
            else send_sample(row.item, row.typed, row.want);
        end

        // random buffers under changing settings
        for (int p = 0; p < PHASES; p++) begin
            fpp   = (p == 7) ? 16'd65535 : (p == 3) ? 16'd0 : 16'($urandom_range(1, 4));
            chans = (p == 2) ? 4'd0 : (p == 5) ? 4'd15 : (p == 8) ? 4'd8
                                                     : 4'($urandom_range(1, 4));
            pix   = 13'($urandom_range(0, 6));
            skip  = 24'($urandom_range(0, 2));
            case (p % 4)
                0: zoom = 16'($urandom);
                1: zoom = 16'd256;
                2: zoom = 16'($urandom_range(0, 25));
                default: zoom = 16'd65535;
            endcase
            // pressure phase: one level per sample while the pass runs, receiver holds off
            if (p == 4) begin
                fpp   = 16'd1;
                chans = 4'd1;
                pix   = 13'd12;
                skip  = 24'd0;
            end
            sender_idles   = (p % 3 != 1) && (p != 4);
            receiver_idles = (p % 4 != 2);
            write_register(REG_FRAMES_PER_PIXEL, 24'(fpp));
            write_register(REG_CHANNEL_COUNT, 24'(chans));
            write_register(REG_PIXEL_COUNT, 24'(pix));
            write_register(REG_SKIP_FRAMES, skip);
            write_register(REG_ZOOM_GAIN, 24'(zoom));
            if (p == 4) hold_off_request = 1'b1;

            span = eff_channels() * (eff_fpp() * eff_pixels() + cfg_skip + 1);
            if (span > 48) span = 48;
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                len = $urandom_range(1, span);
                for (int k = 0; k < len; k++) begin
                    item.sample        = random_sample();
                    item.end_of_buffer = (k == len - 1) || ($urandom_range(0, 31) == 0);
                    send_sample(item, 1'b0, '0);
                    sent++;
                end
            end
        end

        // widest scroll offset: everything skipped
        write_register(REG_SKIP_FRAMES, 24'hFFFFFF);
        for (int k = 0; k < 20; k++) begin
            item.sample        = random_sample();
            item.end_of_buffer = (k == 19);
            send_sample(item, 1'b0, '0);
        end

        // full pixel count, no idling, pass cut short by the buffer end
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        write_register(REG_FRAMES_PER_PIXEL, 24'd1);
        write_register(REG_CHANNEL_COUNT, 24'd1);
        write_register(REG_PIXEL_COUNT, 24'(FULL_PIXELS));
        write_register(REG_SKIP_FRAMES, 24'd0);
        write_register(REG_ZOOM_GAIN, 24'd256);
        for (int k = 0; k < WIDE_ITEMS; k++) begin
            item.sample        = random_sample();
            item.end_of_buffer = (k == WIDE_ITEMS - 1);
            send_sample(item, 1'b0, '0);
        end
        i_in_valid <= 1'b0;

        // drain
        while (levels_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("checked %0d levels from %0d samples across %0d register writes",
                 levels_checked, samples_sent, writes_done);
        $display("settings spanned clamped counts, skipping, saturating zoom and a wide pass");
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hdl/wrwd_pkg.sv
hdl/windowed_rms_waveform_decimator.sv
tb/tb_windowed_rms_waveform_decimator.sv
